>>> rtl/dfd_pkg.sv
package dfd_pkg;

    // opcodes of the input beat
    localparam logic [1:0] OP_FRAME = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    // frame control byte
    localparam logic [7:0] FC_TYPE_MASK    = 8'h0C;
    localparam logic [7:0] FC_SUBTYPE_MASK = 8'hF0;
    localparam logic [7:0] FC_SUB_DEAUTH   = 8'hC0;
    localparam logic [7:0] FC_SUB_DISASSOC = 8'hA0;

    // configuration register indexes
    localparam logic [1:0] CFG_WINDOW_MS       = 2'd0;
    localparam logic [1:0] CFG_ALERT_THRESHOLD = 2'd1;
    localparam logic [1:0] CFG_ALERT_HOLD_MS   = 2'd2;

    localparam logic [31:0] RST_WINDOW_MS       = 32'd1000;
    localparam logic [15:0] RST_ALERT_THRESHOLD = 16'd10;
    localparam logic [31:0] RST_ALERT_HOLD_MS   = 32'd5000;

    localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        CMD_FRAME,
        CMD_SKIP,
        CMD_QUERY,
        CMD_CLEAR
    } t_cmd;

    typedef struct packed {
        t_cmd        cmd;
        logic [47:0] bssid;
        logic [31:0] now_ms;
    } t_cmd_item;

    typedef struct packed {
        logic [47:0] addr;
        logic [31:0] win_begin;
        logic [31:0] tally;
        logic [31:0] sum;
        logic        alert;
        logic [31:0] alert_time;
    } t_entry;

    // result beat, lowest field last
    typedef struct packed {
        logic [3:0]  pad;
        logic [31:0] total_frames;
        logic [31:0] peak_window_count;
        logic [4:0]  active_alerts;
        logic [4:0]  tracked_entries;
        logic [31:0] entry_total;
        logic [31:0] entry_window_count;
        logic        alert_raised;
        logic        counted;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CHK,
        S_NEW,
        S_UPD1,
        S_UPD2,
        S_DONE
    } t_state;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        sat_inc = (v == CNT_MAX) ? v : v + 32'd1;
    endfunction

endpackage

>>> rtl/deauth_flood_detector.sv
// Deauth/disassoc flood detector. Each input beat carries an opcode: frame
// seen, status query (which also expires alerts older than alert_hold_ms) or
// clear. A front stage classifies frames (management, type bits clear,
// subtype deauth or disassoc, non-zero BSSID) and queues up to two commands,
// so up to two beats queue while a result waits on the output. The back
// stage walks the BSSID table held in a single-port memory, reading and then
// checking each entry: a counted frame stops at a hit, a miss or a query scans
// every occupied entry, and a clear or ignored beat skips the table. On a miss
// with a full table the non-alerting entry with the smallest total is replaced
// (first on ties, entry 0 if all alert). Every beat yields exactly one result
// beat. Write configuration only while idle.
module deauth_flood_detector #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // config write channel: index 0 window_ms, 1 alert_threshold, 2 alert_hold_ms
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [1:0]    i_cfg_index,
    input  logic [31:0]   i_cfg_data,
    // input stream
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [87:0]   s_axis_tdata,   // frame_control[7:0], bssid[55:8], now_ms[87:56]
    input  logic [2:0]    s_axis_tuser,   // opcode[1:0], is_management[2]
    // result stream
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [143:0]  m_axis_tdata    // counted[0], alert_raised[1],
                                          // entry_window_count[33:2], entry_total[65:34],
                                          // tracked_entries[70:66], active_alerts[75:71],
                                          // peak_window_count[107:76], total_frames[139:108]
);

    logic [31:0]        r_window_ms;
    logic [15:0]        r_alert_threshold;
    logic [31:0]        r_alert_hold_ms;
    logic               w_cmd_valid;
    logic               w_cmd_pop;
    dfd_pkg::t_cmd_item w_cmd;
    dfd_pkg::t_result   w_result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_ms       <= dfd_pkg::RST_WINDOW_MS;
            r_alert_threshold <= dfd_pkg::RST_ALERT_THRESHOLD;
            r_alert_hold_ms   <= dfd_pkg::RST_ALERT_HOLD_MS;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                dfd_pkg::CFG_WINDOW_MS:       r_window_ms       <= i_cfg_data;
                dfd_pkg::CFG_ALERT_THRESHOLD: r_alert_threshold <= i_cfg_data[15:0];
                dfd_pkg::CFG_ALERT_HOLD_MS:   r_alert_hold_ms   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    dfd_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (s_axis_tvalid),
        .o_ready         (s_axis_tready),
        .i_opcode        (s_axis_tuser[1:0]),
        .i_is_management (s_axis_tuser[2]),
        .i_frame_control (s_axis_tdata[7:0]),
        .i_bssid         (s_axis_tdata[55:8]),
        .i_now_ms        (s_axis_tdata[87:56]),
        .o_cmd_valid     (w_cmd_valid),
        .o_cmd           (w_cmd),
        .i_cmd_pop       (w_cmd_pop)
    );

    dfd_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd_valid       (w_cmd_valid),
        .i_cmd             (w_cmd),
        .o_cmd_pop         (w_cmd_pop),
        .i_window_ms       (r_window_ms),
        .i_alert_threshold (r_alert_threshold),
        .i_alert_hold_ms   (r_alert_hold_ms),
        .o_valid           (m_axis_tvalid),
        .i_ready           (m_axis_tready),
        .o_result          (w_result)
    );

    assign m_axis_tdata = w_result;

endmodule

>>> rtl/dfd_front.sv
module dfd_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [1:0]           i_opcode,
    input  logic                 i_is_management,
    input  logic [7:0]           i_frame_control,
    input  logic [47:0]          i_bssid,
    input  logic [31:0]          i_now_ms,
    output logic                 o_cmd_valid,
    output dfd_pkg::t_cmd_item   o_cmd,
    input  logic                 i_cmd_pop
);

    dfd_pkg::t_cmd_item r_q [2];
    logic               r_wp;
    logic               r_rp;
    logic [1:0]         r_cnt;
    dfd_pkg::t_cmd_item w_item;
    logic               w_push;
    logic               w_pop;
    logic               w_hit_sub;

    // classify the beat
    always_comb begin
        w_hit_sub = ((i_frame_control & dfd_pkg::FC_SUBTYPE_MASK) == dfd_pkg::FC_SUB_DEAUTH)
                 || ((i_frame_control & dfd_pkg::FC_SUBTYPE_MASK) == dfd_pkg::FC_SUB_DISASSOC);
        w_item.bssid  = i_bssid;
        w_item.now_ms = i_now_ms;
        unique case (i_opcode)
            dfd_pkg::OP_FRAME: begin
                if (i_is_management && (i_bssid != 48'd0) && w_hit_sub
                    && ((i_frame_control & dfd_pkg::FC_TYPE_MASK) == 8'd0)) begin
                    w_item.cmd = dfd_pkg::CMD_FRAME;
                end else begin
                    w_item.cmd = dfd_pkg::CMD_SKIP;
                end
            end
            dfd_pkg::OP_QUERY: w_item.cmd = dfd_pkg::CMD_QUERY;
            dfd_pkg::OP_CLEAR: w_item.cmd = dfd_pkg::CMD_CLEAR;
            default:           w_item.cmd = dfd_pkg::CMD_SKIP;
        endcase
    end

    assign o_ready     = (r_cnt != 2'd2);
    assign w_push      = i_valid && o_ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign w_pop       = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_item;
        end
    end

endmodule

>>> rtl/dfd_back.sv
module dfd_back #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    input  dfd_pkg::t_cmd_item i_cmd,
    output logic               o_cmd_pop,
    input  logic [31:0]        i_window_ms,
    input  logic [15:0]        i_alert_threshold,
    input  logic [31:0]        i_alert_hold_ms,
    output logic               o_valid,
    input  logic               i_ready,
    output dfd_pkg::t_result   o_result
);

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CW-1:0] FULL = CW'(TABLE_ENTRIES);

    dfd_pkg::t_entry    r_mem [TABLE_ENTRIES];
    dfd_pkg::t_entry    r_rd;
    dfd_pkg::t_state    r_state, n_state;
    dfd_pkg::t_cmd_item r_cmd;
    logic [CW-1:0]      r_occ;
    logic [31:0]        r_fsum;
    logic [IW-1:0]      r_idx;
    logic [IW-1:0]      r_slot;
    logic [IW-1:0]      r_evict;
    logic               r_found_low;
    logic [31:0]        r_low;
    dfd_pkg::t_entry    r_ent;
    logic [CW-1:0]      r_alerts;
    logic [31:0]        r_peak;
    logic               r_counted;
    logic               r_raised;
    logic               r_out_vld;
    dfd_pkg::t_result   r_out;

    logic               w_we;
    dfd_pkg::t_entry    w_wdata;
    logic [IW-1:0]      w_waddr;
    logic               w_last;
    logic               w_keep;
    logic [31:0]        w_tally;
    logic               w_raise;
    logic               w_out_free;

    assign w_out_free = !r_out_vld || i_ready;
    assign w_last     = ((CW'(r_idx) + CW'(1)) == r_occ);
    assign w_keep     = r_rd.alert && !((r_cmd.now_ms - r_rd.alert_time) > i_alert_hold_ms);
    assign w_tally    = dfd_pkg::sat_inc(r_ent.tally);
    assign w_raise    = (w_tally >= {16'd0, i_alert_threshold}) && !r_ent.alert;
    assign o_valid    = r_out_vld;
    assign o_result   = r_out;

    always_comb begin
        n_state   = r_state;
        o_cmd_pop = 1'b0;
        w_we      = 1'b0;
        w_waddr   = r_slot;
        w_wdata   = r_ent;
        unique case (r_state)
            dfd_pkg::S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    unique case (i_cmd.cmd)
                        dfd_pkg::CMD_FRAME: n_state = (r_occ == '0) ? dfd_pkg::S_NEW
                                                                     : dfd_pkg::S_RD;
                        dfd_pkg::CMD_QUERY: n_state = (r_occ == '0) ? dfd_pkg::S_DONE
                                                                     : dfd_pkg::S_RD;
                        default:            n_state = dfd_pkg::S_DONE;
                    endcase
                end
            end
            dfd_pkg::S_RD: n_state = dfd_pkg::S_CHK;
            dfd_pkg::S_CHK: begin
                if (r_cmd.cmd == dfd_pkg::CMD_FRAME) begin
                    if (r_rd.addr == r_cmd.bssid) begin
                        n_state = dfd_pkg::S_UPD1;
                    end else if (w_last) begin
                        n_state = dfd_pkg::S_NEW;
                    end else begin
                        n_state = dfd_pkg::S_RD;
                    end
                end else begin
                    // query: write back an expired alert
                    w_waddr       = r_idx;
                    w_wdata       = r_rd;
                    w_wdata.alert = w_keep;
                    w_we          = r_rd.alert && !w_keep;
                    n_state       = w_last ? dfd_pkg::S_DONE : dfd_pkg::S_RD;
                end
            end
            dfd_pkg::S_NEW:  n_state = dfd_pkg::S_UPD1;
            dfd_pkg::S_UPD1: n_state = dfd_pkg::S_UPD2;
            dfd_pkg::S_UPD2: begin
                w_we             = 1'b1;
                w_wdata.tally    = w_tally;
                w_wdata.sum      = dfd_pkg::sat_inc(r_ent.sum);
                w_wdata.alert    = r_ent.alert || w_raise;
                w_wdata.alert_time = w_raise ? r_cmd.now_ms : r_ent.alert_time;
                n_state          = dfd_pkg::S_DONE;
            end
            dfd_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_state = dfd_pkg::S_IDLE;
                end
            end
            default: n_state = dfd_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= dfd_pkg::S_IDLE;
            r_occ     <= '0;
            r_fsum    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == dfd_pkg::S_IDLE && i_cmd_valid
                && i_cmd.cmd == dfd_pkg::CMD_CLEAR) begin
                r_occ  <= '0;
                r_fsum <= '0;
            end
            if (r_state == dfd_pkg::S_NEW && r_occ != FULL) begin
                r_occ <= r_occ + CW'(1);
            end
            if (r_state == dfd_pkg::S_UPD2) begin
                r_fsum <= dfd_pkg::sat_inc(r_fsum);
            end
            if (r_state == dfd_pkg::S_DONE && w_out_free) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // table memory, registered read
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (r_state == dfd_pkg::S_RD) begin
            r_rd <= r_mem[r_idx];
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            dfd_pkg::S_IDLE: begin
                r_cmd       <= i_cmd;
                r_idx       <= '0;
                r_slot      <= '0;
                r_evict     <= '0;
                r_found_low <= 1'b0;
                r_low       <= '0;
                r_alerts    <= '0;
                r_peak      <= '0;
                r_counted   <= 1'b0;
                r_raised    <= 1'b0;
                r_ent       <= '0;
            end
            dfd_pkg::S_CHK: begin
                r_idx <= r_idx + IW'(1);
                if (r_cmd.cmd == dfd_pkg::CMD_FRAME) begin
                    if (r_rd.addr == r_cmd.bssid) begin
                        r_slot <= r_idx;
                        r_ent  <= r_rd;
                    end
                    if (!r_rd.alert && (!r_found_low || r_rd.sum < r_low)) begin
                        r_found_low <= 1'b1;
                        r_low       <= r_rd.sum;
                        r_evict     <= r_idx;
                    end
                end else begin
                    r_alerts <= r_alerts + CW'(w_keep);
                    if (r_rd.tally > r_peak) begin
                        r_peak <= r_rd.tally;
                    end
                end
            end
            dfd_pkg::S_NEW: begin
                r_slot           <= (r_occ != FULL) ? r_occ[IW-1:0] : r_evict;
                r_ent.addr       <= r_cmd.bssid;
                r_ent.win_begin  <= r_cmd.now_ms;
                r_ent.tally      <= '0;
                r_ent.sum        <= '0;
                r_ent.alert      <= 1'b0;
                r_ent.alert_time <= '0;
            end
            dfd_pkg::S_UPD1: begin
                if ((r_cmd.now_ms - r_ent.win_begin) > i_window_ms) begin
                    r_ent.tally     <= '0;
                    r_ent.win_begin <= r_cmd.now_ms;
                end
            end
            dfd_pkg::S_UPD2: begin
                r_counted   <= 1'b1;
                r_raised    <= w_raise;
                r_ent.tally <= w_tally;
                r_ent.sum   <= dfd_pkg::sat_inc(r_ent.sum);
            end
            default: begin
            end
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (r_state == dfd_pkg::S_DONE && w_out_free) begin
            r_out.pad                <= '0;
            r_out.total_frames       <= r_fsum;
            r_out.peak_window_count  <= r_peak;
            r_out.active_alerts      <= 5'(r_alerts);
            r_out.tracked_entries    <= 5'(r_occ);
            r_out.entry_total        <= r_counted ? r_ent.sum : 32'd0;
            r_out.entry_window_count <= r_counted ? r_ent.tally : 32'd0;
            r_out.alert_raised       <= r_raised;
            r_out.counted            <= r_counted;
        end
    end

endmodule

>>> verif/tb_deauth_flood_detector.sv
module tb_deauth_flood_detector;

    localparam int NENT = 16;
    localparam int IDLE_LIMIT = 20000;

    // one expected result beat
    typedef struct packed {
        logic        counted;
        logic        alert_raised;
        logic [31:0] entry_window_count;
        logic [31:0] entry_total;
        logic [4:0]  tracked_entries;
        logic [4:0]  active_alerts;
        logic [31:0] peak_window_count;
        logic [31:0] total_frames;
    } t_status;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_cfg_valid;
    logic          o_cfg_ready;
    logic [1:0]    i_cfg_index;
    logic [31:0]   i_cfg_data;
    logic          s_axis_tvalid;
    logic          s_axis_tready;
    logic [87:0]   s_axis_tdata;
    logic [2:0]    s_axis_tuser;
    logic          m_axis_tvalid;
    logic          m_axis_tready;
    logic [143:0]  m_axis_tdata;

    deauth_flood_detector dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // predictor copy of the detector state
    logic [31:0] win_len;
    logic [15:0] thresh;
    logic [31:0] hold_len;
    logic [47:0] bss_addr  [NENT];
    logic [31:0] win_start [NENT];
    logic [31:0] win_cnt   [NENT];
    logic [31:0] bss_total [NENT];
    logic        alerting  [NENT];
    logic [31:0] alert_at  [NENT];
    int          n_tracked;
    logic [31:0] all_frames;

    t_status pending_status[$];
    int      n_errors;
    int      n_beats_in;
    int      n_beats_out;
    int      n_counted;
    int      n_alerts;
    int      idle_cycles;
    bit      hold_off_rx;
    int      hold_off_len;
    int      rx_wait;
    int      rx_draw;

    function automatic logic [31:0] bump(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    // find or allocate the BSSID entry of one counted frame; returns the entry
    function automatic int claim_entry(input logic [47:0] a, input logic [31:0] t);
        int e;
        bit got;
        logic [31:0] low;
        e = 0;
        got = 0;
        low = '0;
        for (int k = 0; k < n_tracked; k++)
            if (bss_addr[k] == a) return k;
        if (n_tracked >= NENT) begin
            for (int k = 0; k < NENT; k++) begin
                if (!alerting[k] && (!got || bss_total[k] < low)) begin
                    got = 1;
                    low = bss_total[k];
                    e = k;
                end
            end
        end else begin
            e = n_tracked;
            n_tracked++;
        end
        bss_addr[e]  = a;
        win_start[e] = t;
        win_cnt[e]   = '0;
        bss_total[e] = '0;
        alerting[e]  = 1'b0;
        alert_at[e]  = '0;
        return e;
    endfunction

    function automatic t_status predict_status(input logic [1:0] op, input logic mgmt,
                                               input logic [7:0] fc, input logic [47:0] a,
                                               input logic [31:0] t);
        t_status r;
        int e;
        r = '0;
        if (op == dfd_pkg::OP_FRAME) begin
            if (mgmt && a != 0 && (fc & dfd_pkg::FC_TYPE_MASK) == 0 &&
                ((fc & dfd_pkg::FC_SUBTYPE_MASK) == dfd_pkg::FC_SUB_DEAUTH ||
                 (fc & dfd_pkg::FC_SUBTYPE_MASK) == dfd_pkg::FC_SUB_DISASSOC)) begin
                e = claim_entry(a, t);
                if (32'(t - win_start[e]) > win_len) begin
                    win_cnt[e] = '0;
                    win_start[e] = t;
                end
                win_cnt[e]   = bump(win_cnt[e]);
                bss_total[e] = bump(bss_total[e]);
                all_frames   = bump(all_frames);
                r.counted = 1'b1;
                if (win_cnt[e] >= {16'd0, thresh} && !alerting[e]) begin
                    alerting[e] = 1'b1;
                    alert_at[e] = t;
                    r.alert_raised = 1'b1;
                end
                r.entry_window_count = win_cnt[e];
                r.entry_total = bss_total[e];
            end
        end else if (op == dfd_pkg::OP_QUERY) begin
            for (int k = 0; k < n_tracked; k++) begin
                if (alerting[k] && 32'(t - alert_at[k]) > hold_len) alerting[k] = 1'b0;
                if (alerting[k]) r.active_alerts++;
                if (win_cnt[k] > r.peak_window_count) r.peak_window_count = win_cnt[k];
            end
        end else if (op == dfd_pkg::OP_CLEAR) begin
            n_tracked = 0;
            all_frames = '0;
        end
        r.tracked_entries = 5'(n_tracked);
        r.total_frames = all_frames;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("ERROR beat %0d: %s got %0h expected %0h", n_beats_out, what, got, want);
        n_errors++;
    endtask

    // one input beat; prediction happens at acceptance. Valid stays up after
    // acceptance until the next beat or a drain drops it.
    task automatic send_beat(input logic [1:0] op, input logic mgmt, input logic [7:0] fc,
                             input logic [47:0] a, input logic [31:0] t, input bit no_gap = 0);
        int gap;
        t_status r;
        gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10));
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= {mgmt, op};
        s_axis_tdata  <= {t, a, fc};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        r = predict_status(op, mgmt, fc, a, t);
        pending_status.push_back(r);
        n_beats_in++;
    endtask

    task automatic send_frame(input logic [47:0] a, input logic [31:0] t);
        send_beat(dfd_pkg::OP_FRAME, 1'b1,
                  ($urandom_range(0, 1) ? dfd_pkg::FC_SUB_DEAUTH : dfd_pkg::FC_SUB_DISASSOC)
                  | 8'($urandom_range(0, 3)), a, t);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_status.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    // valid stays up across back-to-back writes; set_config drops it
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            dfd_pkg::CFG_WINDOW_MS:       win_len  = v;
            dfd_pkg::CFG_ALERT_THRESHOLD: thresh   = v[15:0];
            dfd_pkg::CFG_ALERT_HOLD_MS:   hold_len = v;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [31:0] w, input logic [15:0] th,
                              input logic [31:0] h);
        wait_drained();
        write_reg(dfd_pkg::CFG_WINDOW_MS, w);
        write_reg(dfd_pkg::CFG_ALERT_THRESHOLD, {16'd0, th});
        write_reg(dfd_pkg::CFG_ALERT_HOLD_MS, h);
        i_cfg_valid <= 1'b0;
    endtask

    // receiver: randomly delays ready after each accepted beat, and holds off while hold_off_rx is set
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_wait <= 0;
        end else if (hold_off_rx) begin
            m_axis_tready <= 1'b0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            rx_draw = $urandom_range(0, 10);
            rx_wait <= rx_draw;
            m_axis_tready <= (rx_draw == 0);
        end else if (rx_wait > 0) begin
            rx_wait <= rx_wait - 1;
            m_axis_tready <= (rx_wait == 1);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // checker of each result beat
    always @(posedge i_clk) begin
        t_status got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_beats_out++;
            got = {m_axis_tdata[0], m_axis_tdata[1], m_axis_tdata[33:2], m_axis_tdata[65:34],
                   m_axis_tdata[70:66], m_axis_tdata[75:71], m_axis_tdata[107:76],
                   m_axis_tdata[139:108]};
            if (pending_status.size() == 0) begin
                $display("ERROR: result beat with nothing expected");
                n_errors++;
            end else begin
                want = pending_status.pop_front();
                if (want.counted) n_counted++;
                if (want.alert_raised) n_alerts++;
                if (got.counted != want.counted)
                    report_mismatch("counted", 32'(got.counted), 32'(want.counted));
                if (got.alert_raised != want.alert_raised)
                    report_mismatch("alert_raised", 32'(got.alert_raised),
                                    32'(want.alert_raised));
                if (got.entry_window_count != want.entry_window_count)
                    report_mismatch("entry_window_count", got.entry_window_count,
                                    want.entry_window_count);
                if (got.entry_total != want.entry_total)
                    report_mismatch("entry_total", got.entry_total, want.entry_total);
                if (got.tracked_entries != want.tracked_entries)
                    report_mismatch("tracked_entries", 32'(got.tracked_entries),
                                    32'(want.tracked_entries));
                if (got.active_alerts != want.active_alerts)
                    report_mismatch("active_alerts", 32'(got.active_alerts),
                                    32'(want.active_alerts));
                if (got.peak_window_count != want.peak_window_count)
                    report_mismatch("peak_window_count", got.peak_window_count,
                                    want.peak_window_count);
                if (got.total_frames != want.total_frames)
                    report_mismatch("total_frames", got.total_frames, want.total_frames);
            end
        end
    end

    // watchdog: cycles with no beat moving on any channel
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready) || hold_off_rx)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout, %0d results still expected", pending_status.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // long receiver hold-off, counted in its own process
    always @(posedge i_clk) begin
        if (hold_off_len > 0) begin
            hold_off_len <= hold_off_len - 1;
            if (hold_off_len == 1) hold_off_rx <= 1'b0;
        end
    end

    // ---------------- tests ----------------

    // field extremes, every opcode, each filter condition
    task automatic test_directed();
        send_beat(dfd_pkg::OP_QUERY, 1'b0, 8'h00, 48'h0, 32'h0);
        // zero BSSID, not management, type bits, other subtype
        send_beat(dfd_pkg::OP_FRAME, 1'b1, dfd_pkg::FC_SUB_DEAUTH, 48'h0, 32'd5);
        send_beat(dfd_pkg::OP_FRAME, 1'b0, dfd_pkg::FC_SUB_DEAUTH, 48'h1, 32'd5);
        send_beat(dfd_pkg::OP_FRAME, 1'b1, dfd_pkg::FC_SUB_DEAUTH | 8'h04, 48'h1, 32'd5);
        send_beat(dfd_pkg::OP_FRAME, 1'b1, dfd_pkg::FC_SUB_DEAUTH | 8'h08, 48'h1, 32'd5);
        send_beat(dfd_pkg::OP_FRAME, 1'b1, 8'hB0, 48'h1, 32'd5);
        send_beat(dfd_pkg::OP_FRAME, 1'b1, 8'hFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        send_beat(dfd_pkg::OP_FRAME, 1'b1, dfd_pkg::FC_SUB_DEAUTH | 8'h03,
                  48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        // wrap of time, then a window restart
        send_beat(dfd_pkg::OP_FRAME, 1'b1, dfd_pkg::FC_SUB_DISASSOC, 48'h1, 32'd0);
        send_beat(dfd_pkg::OP_FRAME, 1'b1, dfd_pkg::FC_SUB_DISASSOC, 48'h1, 32'd1000);
        send_beat(dfd_pkg::OP_FRAME, 1'b1, dfd_pkg::FC_SUB_DISASSOC, 48'h1, 32'd1001);
        send_beat(dfd_pkg::OP_NONE, 1'b1, 8'hFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        for (int k = 0; k < 9; k++)
            send_beat(dfd_pkg::OP_FRAME, 1'b1, dfd_pkg::FC_SUB_DEAUTH, 48'h1, 32'd1100);
        // just expired
        send_beat(dfd_pkg::OP_QUERY, 1'b1, 8'hFF, 48'hFFFF_FFFF_FFFF, 32'd6101);
        send_beat(dfd_pkg::OP_CLEAR, 1'b1, 8'hFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        send_beat(dfd_pkg::OP_QUERY, 1'b0, 8'h00, 48'h0, 32'h0);
    endtask

    // fill past 16 entries so eviction picks the lowest non-alerting one
    task automatic test_table_full(input logic [15:0] th);
        set_config(32'd1000, th, 32'hFFFF_FFFF);
        send_beat(dfd_pkg::OP_CLEAR, 1'b0, 8'h0, 48'h0, 32'h0);
        for (int k = 0; k < 40; k++)
            send_frame(48'h100 + 48'($urandom_range(0, 24)), $urandom_range(0, 3000));
        send_beat(dfd_pkg::OP_QUERY, 1'b0, 8'h0, 48'h0, 32'd100);
    endtask

    // all entries alerting: eviction falls on entry 0
    task automatic test_all_alerting();
        set_config(32'd1000, 16'd1, 32'hFFFF_FFFF);
        send_beat(dfd_pkg::OP_CLEAR, 1'b0, 8'h0, 48'h0, 32'h0);
        for (int k = 0; k < 20; k++) send_frame(48'h5000 + 48'(k), 32'(k));
        send_beat(dfd_pkg::OP_QUERY, 1'b0, 8'h0, 48'h0, 32'd30);
    endtask

    // sender keeps offering while the receiver holds off
    task automatic test_backpressure();
        wait_drained();
        hold_off_rx <= 1'b1;
        hold_off_len <= 300;
        for (int k = 0; k < 12; k++)
            send_beat(dfd_pkg::OP_FRAME, 1'b1, dfd_pkg::FC_SUB_DEAUTH, 48'h77, 32'(k), 1);
        wait_drained();
    endtask

    task automatic random_beat(input int nb);
        logic [1:0] op;
        logic [31:0] t0;
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            send_frame(48'hA0_0000 + 48'($urandom_range(0, nb)), $urandom_range(0, 2500));
        end else if (r < 80) begin
            send_beat(dfd_pkg::OP_QUERY, 1'($urandom), 8'($urandom),
                      {16'($urandom), 32'($urandom)}, $urandom_range(0, 9000));
        end else if (r < 82) begin
            send_beat(dfd_pkg::OP_CLEAR, 1'($urandom), 8'($urandom),
                      {16'($urandom), 32'($urandom)}, $urandom);
        end else begin
            op = (r < 84) ? dfd_pkg::OP_NONE : dfd_pkg::OP_FRAME;
            t0 = $urandom;
            send_beat(op, 1'($urandom), 8'($urandom), {16'($urandom), 32'($urandom)}, t0);
        end
    endtask

    task automatic test_random(input int n, input int nb);
        for (int k = 0; k < n; k++) random_beat(nb);
    endtask

    // near-saturation and extreme registers
    task automatic test_extremes();
        set_config(32'hFFFF_FFFF, 16'hFFFF, 32'd0);
        test_random(100, 6);
        set_config(32'd1, 16'd1, 32'd0);
        test_random(100, 20);
        send_beat(dfd_pkg::OP_QUERY, 1'b0, 8'h0, 48'h0, 32'hFFFF_FFFF);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = dfd_pkg::CFG_WINDOW_MS;
        i_cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        hold_off_rx = 1'b0;
        hold_off_len = 0;
        idle_cycles = 0;
        n_errors = 0;
        n_beats_in = 0;
        n_beats_out = 0;
        n_counted = 0;
        n_alerts = 0;
        win_len = dfd_pkg::RST_WINDOW_MS;
        thresh = dfd_pkg::RST_ALERT_THRESHOLD;
        hold_len = dfd_pkg::RST_ALERT_HOLD_MS;
        n_tracked = 0;
        all_frames = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_table_full(16'd3);
        test_all_alerting();
        test_backpressure();
        set_config(32'd300, 16'd4, 32'd2000);
        test_random(500, 10);
        set_config(32'd1000, 16'd8, 32'd500);
        test_random(450, 30);
        test_extremes();
        set_config(dfd_pkg::RST_WINDOW_MS, dfd_pkg::RST_ALERT_THRESHOLD,
                   dfd_pkg::RST_ALERT_HOLD_MS);
        test_random(150, 12);

        wait_drained();
        $display("covered %0d beats in, %0d results, %0d counted frames, %0d alerts raised",
                 n_beats_in, n_beats_out, n_counted, n_alerts);
        $display("includes table eviction, window restarts, expiry and a long output stall");
        if (n_errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
